// ===== src/tsfs_pkg.sv =====
`timescale 1ns / 1ps
package tsfs_pkg;
  localparam int unsigned DefMaxSamples = 256;
  localparam int unsigned DefMaxFeatures = 65536;
  localparam int unsigned DefSampleBits = 12;
  localparam logic [1:0] RegFirstLabel = 2'd0;
  localparam logic [1:0] RegSecondLabel = 2'd1;
  localparam logic [1:0] RegZeroVarFloor = 2'd2;
  typedef logic [63:0] word_t;
endpackage

// ===== src/t_statistic_feature_select.sv =====
`timescale 1ns / 1ps
// Two-sample t statistic feature selector. Samples enter on s_axis (tdata: sample_value,
// sample_label; tuser: last_feature; tlast: last_sample). A sample can be taken in every cycle
// while idle. A row end runs a sequencer around one shared 33x33 signed multiplier: the t
// squared fraction and its exact cross-multiplied comparison against the best (skipped
// when a group is empty) keep s_axis_tready low until the result is loaded into the output
// register, also while the previous result still waits there. One result per row goes out
// on m_axis (tlast: done_res) through that register; new samples are taken while it waits.
module t_statistic_feature_select
  import tsfs_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = DefMaxSamples,
  parameter int unsigned MAX_FEATURES = DefMaxFeatures,
  parameter int unsigned SAMPLE_BITS = DefSampleBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // sample_value[11:0], sample_label[19:12], zero fill
  input  logic        s_axis_tlast,
  input  logic        s_axis_tuser,  // last_feature
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // feature_index[15:0], best_index[31:16]
  output logic        m_axis_tlast,
  output logic [2:0]  m_axis_tuser   // row_is_new_best, best_valid, empty_class
);
  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned RowW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int unsigned SumW = SAMPLE_BITS + CntW;
  localparam int unsigned SqW = 2 * SAMPLE_BITS + CntW;

  localparam logic [4:0] StIdle = 5'd0;
  localparam logic [4:0] StD1 = 5'd1;
  localparam logic [4:0] StD2 = 5'd2;
  localparam logic [4:0] StNum = 5'd3;
  localparam logic [4:0] StV1a = 5'd4;
  localparam logic [4:0] StV1b = 5'd5;
  localparam logic [4:0] StV2a = 5'd6;
  localparam logic [4:0] StV2b = 5'd7;
  localparam logic [4:0] StN1s = 5'd8;
  localparam logic [4:0] StN2s = 5'd9;
  localparam logic [4:0] StE1 = 5'd10;
  localparam logic [4:0] StE2 = 5'd11;
  localparam logic [4:0] StCa = 5'd12;
  localparam logic [4:0] StCb = 5'd13;
  localparam logic [4:0] StDone = 5'd14;
  localparam logic [4:0] StOut = 5'd15;
  localparam logic [4:0] StF1 = 5'd16;
  localparam logic [4:0] StF2 = 5'd17;
  localparam logic [4:0] StE1h = 5'd18;
  localparam logic [4:0] StE2h = 5'd19;

  logic [7:0] lab1_q, lab2_q;
  logic [15:0] floor_q;
  logic [CntW-1:0] n1_q, n2_q;
  logic signed [SumW-1:0] s1_q, s2_q;
  logic [SqW-1:0] q1_q, q2_q;
  logic [RowW-1:0] row_q, best_row_q;
  logic best_valid_q;
  logic [63:0] bnum_q, bden_q;
  logic [4:0] st_q;
  logic last_f_q;
  logic [3:0] k_q;
  logic signed [63:0] acc_q, t_q;
  logic [63:0] num_q, den_q, n2sq_q, n1sq_q;
  logic [127:0] pa_q, pb_q;
  logic signed [63:0] v1_q;

  // shared multiplier: 33x33 signed
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  assign mp = ma * mb;

  logic signed [SAMPLE_BITS-1:0] v;
  logic signed [2*SAMPLE_BITS-1:0] vsq;
  logic [7:0] lab;
  logic room, hit1, hit2;
  assign v = s_axis_tdata[SAMPLE_BITS-1:0];
  assign vsq = v * v;
  assign lab = s_axis_tdata[19:12];
  assign room = ({1'b0, n1_q} + {1'b0, n2_q}) < (CntW + 1)'(MAX_SAMPLES);
  assign hit1 = room && lab == lab1_q;
  assign hit2 = room && !hit1 && lab == lab2_q;

  assign s_axis_tready = st_q == StIdle;
  wire s_acc = s_axis_tvalid && s_axis_tready;

  // operand selection for the shared multiplier; partial products for 64x64 unsigned compares
  logic [31:0] xa, xb;
  always_comb begin
    ma = '0;
    mb = '0;
    xa = '0;
    xb = '0;
    unique case (st_q)
      StD1: begin ma = 33'(s1_q); mb = 33'($signed({1'b0, n2_q})); end
      StD2: begin ma = 33'(s2_q); mb = 33'($signed({1'b0, n1_q})); end
      StNum: begin ma = {1'b0, acc_q[31:0]}; mb = {1'b0, acc_q[31:0]}; end
      StV1a: begin ma = {1'b0, 32'(q1_q)}; mb = 33'($signed({1'b0, n1_q})); end
      StV1b: begin ma = 33'(s1_q); mb = 33'(s1_q); end
      StV2a: begin ma = {1'b0, 32'(q2_q)}; mb = 33'($signed({1'b0, n2_q})); end
      StV2b: begin ma = 33'(s2_q); mb = 33'(s2_q); end
      StN1s: begin ma = 33'($signed({1'b0, n1_q})); mb = 33'($signed({1'b0, n1_q})); end
      StN2s: begin ma = 33'($signed({1'b0, n2_q})); mb = 33'($signed({1'b0, n2_q})); end
      StE1, StF1: begin ma = {1'b0, t_q[31:0]}; mb = {1'b0, n2sq_q[31:0]}; end
      StE1h: begin ma = {1'b0, t_q[63:32]}; mb = {1'b0, n2sq_q[31:0]}; end
      StE2: begin ma = {1'b0, acc_q[31:0]}; mb = {1'b0, n1sq_q[31:0]}; end
      StE2h: begin ma = {1'b0, acc_q[63:32]}; mb = {1'b0, n1sq_q[31:0]}; end
      StF2: begin ma = {1'b0, t_q[31:0]}; mb = 33'($signed({1'b0, n1_q})); end
      StCa: begin
        xa = k_q[0] ? num_q[63:32] : num_q[31:0];
        xb = k_q[1] ? bden_q[63:32] : bden_q[31:0];
        ma = {1'b0, xa}; mb = {1'b0, xb};
      end
      StCb: begin
        xa = k_q[0] ? bnum_q[63:32] : bnum_q[31:0];
        xb = k_q[1] ? den_q[63:32] : den_q[31:0];
        ma = {1'b0, xa}; mb = {1'b0, xb};
      end
      default: ;
    endcase
  end

  wire [127:0] part = {62'd0, mp} << {({1'b0, k_q[1]} + {1'b0, k_q[0]}), 5'd0};
  wire better = pa_q > pb_q;
  wire win = (st_q == StOut) && better;
  wire out_load = ((st_q == StOut) || (st_q == StDone)) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lab1_q <= 8'd0;
      lab2_q <= 8'd1;
      floor_q <= 16'd1;
      n1_q <= '0; n2_q <= '0; s1_q <= '0; s2_q <= '0; q1_q <= '0; q2_q <= '0;
      row_q <= '0; best_row_q <= '0; best_valid_q <= 1'b0;
      bnum_q <= '0; bden_q <= 64'd1;
      st_q <= StIdle;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata <= '0;
      m_axis_tlast <= 1'b0;
      m_axis_tuser <= '0;
      last_f_q <= 1'b0;
      k_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegFirstLabel: lab1_q <= cfg_data_i[7:0];
          RegSecondLabel: lab2_q <= cfg_data_i[7:0];
          RegZeroVarFloor: floor_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (st_q)
        StIdle: if (s_acc) begin
          if (hit1) begin
            n1_q <= n1_q + 1'b1;
            s1_q <= s1_q + SumW'(v);
            q1_q <= q1_q + SqW'($unsigned(vsq));
          end else if (hit2) begin
            n2_q <= n2_q + 1'b1;
            s2_q <= s2_q + SumW'(v);
            q2_q <= q2_q + SqW'($unsigned(vsq));
          end
          last_f_q <= s_axis_tuser;
          if (s_axis_tlast) st_q <= StD1;
        end
        StD1: begin
          acc_q <= 64'(mp);
          st_q <= (n1_q == 0 || n2_q == 0) ? StDone : StD2;
        end
        StD2: begin
          acc_q <= acc_q - 64'(mp);
          st_q <= StNum;
        end
        StNum: begin
          if (acc_q < 0) acc_q <= -acc_q; else st_q <= StV1a;
          if (acc_q >= 0) num_q <= 64'(mp);
        end
        StV1a: begin t_q <= 64'(mp); st_q <= StV1b; end
        StV1b: begin
          v1_q <= (t_q - 64'(mp)) < 0 ? '0 : t_q - 64'(mp);
          st_q <= StV2a;
        end
        StV2a: begin t_q <= 64'(mp); st_q <= StV2b; end
        StV2b: begin
          acc_q <= (t_q - 64'(mp)) < 0 ? '0 : t_q - 64'(mp);
          st_q <= StN1s;
        end
        StN1s: begin n1sq_q <= 64'(mp); st_q <= StN2s; end
        StN2s: begin
          n2sq_q <= 64'(mp);
          if (v1_q == 0 && acc_q == 0) begin
            t_q <= {48'd0, (floor_q == 0) ? 16'd1 : floor_q};
            st_q <= StF1;
          end else begin
            t_q <= v1_q;
            st_q <= StE1;
          end
        end
        // variance terms exceed 32 bits: low and high halves in turn
        StE1: begin den_q <= 64'(mp); st_q <= StE1h; end
        StE1h: begin den_q <= den_q + (64'(mp) << 32); st_q <= StE2; end
        StE2: begin den_q <= den_q + 64'(mp); st_q <= StE2h; end
        StE2h: begin
          den_q <= den_q + (64'(mp) << 32);
          k_q <= '0; pa_q <= '0; pb_q <= '0;
          st_q <= StCa;
        end
        StF1: begin t_q <= 64'(mp); st_q <= StF2; end
        StF2: begin
          den_q <= 64'(mp);
          k_q <= '0; pa_q <= '0; pb_q <= '0;
          st_q <= StCa;
        end
        StCa: begin
          pa_q <= pa_q + part;
          if (k_q[1:0] == 2'd3) begin
            k_q <= '0;
            st_q <= StCb;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        StCb: begin
          pb_q <= pb_q + part;
          k_q <= k_q + 1'b1;
          if (k_q[1:0] == 2'd3) st_q <= StOut;
        end
        StOut, StDone: if (out_load) begin
          m_axis_tdata <= {16'(win ? row_q : best_row_q), 16'(row_q)};
          m_axis_tlast <= last_f_q;
          m_axis_tuser <= {st_q == StDone, best_valid_q || win, win};
          n1_q <= '0; n2_q <= '0; s1_q <= '0; s2_q <= '0; q1_q <= '0; q2_q <= '0;
          if (last_f_q) begin
            row_q <= '0; bnum_q <= '0; bden_q <= 64'd1;
            best_row_q <= '0; best_valid_q <= 1'b0;
          end else begin
            row_q <= (MAX_FEATURES > 1) ? row_q + 1'b1 : '0;
            if (win) begin
              bnum_q <= num_q; bden_q <= den_q;
              best_row_q <= row_q; best_valid_q <= 1'b1;
            end
          end
          st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule

// ===== src/tsfs_checker.sv =====
`timescale 1ns / 1ps
module tsfs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("ready after row end");
  a_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[1] && !m_axis_tuser[2]
    && m_axis_tdata[15:0] == m_axis_tdata[31:16])
    else $error("new best inconsistent");
  a_inv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[31:16] == 16'd0)
    else $error("best index without valid");
endmodule

bind t_statistic_feature_select tsfs_checker u_tsfs_checker (.*);

// ===== tb/tb_t_statistic_feature_select.sv =====
`timescale 1ns / 1ps
module tb_t_statistic_feature_select;
  import tsfs_pkg::*;

  localparam int NRAND = 660;
  localparam longint CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [15:0] feature_index;
    logic        row_is_new_best;
    logic [15:0] best_index;
    logic        best_valid;
    logic        empty_class;
    logic        done_res;
  } row_result_t;

  typedef struct {
    logic [11:0] value;
    logic [7:0]  label;
    logic        last_s;
    logic        last_f;
    logic        has_exp;
    row_result_t exp_res;
  } sample_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [2:0]  m_axis_tuser;

  t_statistic_feature_select dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [7:0]  lab1 = 8'd0, lab2 = 8'd1;
  logic [15:0] var_floor = 16'd1;
  longint      n1, n2, s1, s2, q1, q2;
  longint unsigned rows_seen;
  logic [127:0] best_num, best_den;
  logic [15:0] best_row;
  logic        best_ok;

  row_result_t row_results_q[$];
  int          errors = 0;
  longint      cycles = 0;
  bit          hold_off = 1'b0;
  bit          stim_done = 1'b0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic clear_search_state();
    rows_seen = 0;
    best_num = 0;
    best_den = 1;
    best_row = 0;
    best_ok = 1'b0;
  endtask

  function automatic void clear_row_state();
    n1 = 0; n2 = 0; s1 = 0; s2 = 0; q1 = 0; q2 = 0;
  endfunction

  // returns 1 and the row result when the sample closes a row
  function automatic bit predict_sample(input logic [11:0] value, input logic [7:0] label,
                                        input logic last_s, input logic last_f,
                                        output row_result_t res);
    longint v, d, v1, v2;
    logic [127:0] num, den, lhs, rhs;
    bit better, empty;
    v = longint'($signed(value));
    better = 1'b0;
    res = '0;
    if (n1 + n2 < 256) begin
      if (label == lab1) begin
        n1++; s1 += v; q1 += v * v;
      end else if (label == lab2) begin
        n2++; s2 += v; q2 += v * v;
      end
    end
    if (!last_s) return 1'b0;
    empty = (n1 == 0) || (n2 == 0);
    if (!empty) begin
      d = s1 * n2 - s2 * n1;
      if (d < 0) d = -d;
      num = 128'(d) * 128'(d);
      v1 = n1 * q1 - s1 * s1;
      v2 = n2 * q2 - s2 * s2;
      if (v1 < 0) v1 = 0;
      if (v2 < 0) v2 = 0;
      if (v1 == 0 && v2 == 0)
        den = 128'((var_floor == 0) ? 16'd1 : var_floor) * 128'(n1) * 128'(n2 * n2);
      else
        den = 128'(v1) * 128'(n2 * n2) + 128'(v2) * 128'(n1 * n1);
      lhs = num * best_den;
      rhs = best_num * den;
      if (lhs > rhs) begin
        better = 1'b1;
        best_num = num;
        best_den = den;
        best_row = rows_seen[15:0];
        best_ok = 1'b1;
      end
    end
    res.feature_index = rows_seen[15:0];
    res.row_is_new_best = better;
    res.best_index = best_row;
    res.best_valid = best_ok;
    res.empty_class = empty;
    res.done_res = last_f;
    clear_row_state();
    rows_seen = (rows_seen + 1) % 65536;
    if (last_f) begin
      rows_seen = 0;
      best_num = 0;
      best_den = 1;
      best_row = 0;
      best_ok = 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic random_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 55) return;
    s_axis_tvalid <= 1'b0;
    if (r < 95) repeat ($urandom_range(1, 3)) @(negedge clk_i);
    else repeat ($urandom_range(10, 40)) @(negedge clk_i);
  endtask

  task automatic send_sample(input sample_row_t row);
    row_result_t res;
    if (predict_sample(row.value, row.label, row.last_s, row.last_f, res)) begin
      if (row.has_exp && res !== row.exp_res)
        report("directed row", 64'(res), 64'(row.exp_res));
      row_results_q.push_back(res);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'd0, row.label, row.value};
    s_axis_tlast <= row.last_s;
    s_axis_tuser <= row.last_f;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic drain_then_idle();
    s_axis_tvalid <= 1'b0;
    while (row_results_q.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      RegFirstLabel:   lab1 = val[7:0];
      RegSecondLabel:  lab2 = val[7:0];
      RegZeroVarFloor: var_floor = val;
      default: ;
    endcase
  endtask

  function automatic sample_row_t mk(input logic [11:0] v, input logic [7:0] l,
                                     input logic ls, input logic lf);
    sample_row_t r;
    r.value = v; r.label = l; r.last_s = ls; r.last_f = lf;
    r.has_exp = 1'b0; r.exp_res = '0;
    return r;
  endfunction

  function automatic sample_row_t mke(input logic [11:0] v, input logic [7:0] l,
                                      input logic ls, input logic lf, input row_result_t e);
    sample_row_t r;
    r = mk(v, l, ls, lf);
    r.has_exp = 1'b1; r.exp_res = e;
    return r;
  endfunction

  task automatic random_rows(input int n_items, input bit noisy);
    int sent, len, k;
    logic [11:0] v;
    logic [7:0] l;
    bit ls, lf;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 19) == 0) ? int'($urandom_range(200, 300))
                                         : int'($urandom_range(1, 12));
      for (k = 0; k < len; k++) begin
        case ($urandom_range(0, 9))
          0: v = 12'h800;
          1: v = 12'h7ff;
          default: v = 12'($urandom);
        endcase
        if (noisy && $urandom_range(0, 5) == 0) l = 8'($urandom);
        else l = $urandom_range(0, 1) ? lab1 : lab2;
        if ($urandom_range(0, 3) == 0) v = 12'(k % 3);
        ls = (k == len - 1);
        lf = ls ? ($urandom_range(0, 7) == 0) : 1'($urandom_range(0, 1));
        send_sample(mk(v, l, ls, lf));
        random_gap();
        sent++;
      end
    end
  endtask

  // stimulus
  initial begin
    sample_row_t dir_q[$];
    row_result_t e;
    clear_row_state();
    clear_search_state();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty group after reset
    e = '0; e.empty_class = 1'b1;
    dir_q.push_back(mke(12'h7ff, 8'd0, 1'b1, 1'b0, e));
    // extremes: one sample each group
    dir_q.push_back(mk(12'h800, 8'd0, 1'b0, 1'b1));
    e = '0; e.feature_index = 16'd1; e.row_is_new_best = 1'b1; e.best_index = 16'd1;
    e.best_valid = 1'b1;
    dir_q.push_back(mke(12'h7ff, 8'd1, 1'b1, 1'b0, e));
    // an ignored label, then a row with both groups filled
    dir_q.push_back(mk(12'h005, 8'hff, 1'b0, 1'b0));
    dir_q.push_back(mk(12'h005, 8'd0, 1'b0, 1'b0));
    dir_q.push_back(mk(12'h005, 8'd1, 1'b0, 1'b0));
    dir_q.push_back(mk(12'h003, 8'd0, 1'b0, 1'b0));
    dir_q.push_back(mk(12'hffd, 8'd1, 1'b1, 1'b0));
    // zero t row, last row
    dir_q.push_back(mk(12'h000, 8'd0, 1'b0, 1'b0));
    e = '0; e.feature_index = 16'd3; e.best_index = 16'd1; e.best_valid = 1'b1;
    e.done_res = 1'b1;
    dir_q.push_back(mke(12'h000, 8'd1, 1'b1, 1'b1, e));
    // search cleared
    dir_q.push_back(mk(12'h100, 8'd0, 1'b0, 1'b0));
    dir_q.push_back(mk(12'h200, 8'd1, 1'b0, 1'b0));
    dir_q.push_back(mk(12'h180, 8'd1, 1'b1, 1'b0));
    foreach (dir_q[i]) send_sample(dir_q[i]);

    drain_then_idle();
    // equal labels and floor of zero
    write_reg(RegFirstLabel, 16'd1);
    write_reg(RegZeroVarFloor, 16'd0);
    send_sample(mk(12'h001, 8'd1, 1'b0, 1'b0));
    send_sample(mk(12'h002, 8'd1, 1'b1, 1'b0));
    drain_then_idle();
    write_reg(RegFirstLabel, 16'd255);
    write_reg(RegSecondLabel, 16'd0);
    write_reg(RegZeroVarFloor, 16'hffff);
    send_sample(mk(12'h7ff, 8'd255, 1'b0, 1'b0));
    send_sample(mk(12'h800, 8'd0, 1'b1, 1'b0));
    // too many samples in one row
    for (int k = 0; k < 300; k++)
      send_sample(mk(12'($urandom), (k % 2) ? 8'd0 : 8'd255, k == 299, 1'b0));

    // long receiver hold-off while the sender keeps going
    hold_off = 1'b1;
    random_rows(60, 1'b0);
    drain_then_idle();

    write_reg(RegFirstLabel, 16'd7);
    write_reg(RegSecondLabel, 16'd200);
    write_reg(RegZeroVarFloor, 16'd1);
    random_rows(NRAND / 2, 1'b1);
    drain_then_idle();
    write_reg(RegZeroVarFloor, 16'd300);
    random_rows(NRAND / 2, 1'b1);
    send_sample(mk(12'h000, lab1, 1'b1, 1'b1));
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver
  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        for (hold = 0; hold < 600; hold++) @(negedge clk_i);
        hold_off = 1'b0;
      end
      case ($urandom_range(0, 19))
        0: begin
          m_axis_tready <= 1'b0;
          repeat ($urandom_range(20, 80)) @(negedge clk_i);
          m_axis_tready <= 1'b1;
        end
        1, 2, 3, 4: m_axis_tready <= 1'b0;
        default: m_axis_tready <= 1'b1;
      endcase
    end
  end

  // checker
  always @(posedge clk_i) begin
    row_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.feature_index = m_axis_tdata[15:0];
      got.best_index = m_axis_tdata[31:16];
      got.row_is_new_best = m_axis_tuser[0];
      got.best_valid = m_axis_tuser[1];
      got.empty_class = m_axis_tuser[2];
      got.done_res = m_axis_tlast;
      if (row_results_q.size() == 0) begin
        report("unexpected result", 64'(got), 64'd0);
      end else begin
        want = row_results_q.pop_front();
        if (got.feature_index !== want.feature_index)
          report("feature_index", 64'(got.feature_index), 64'(want.feature_index));
        if (got.row_is_new_best !== want.row_is_new_best)
          report("row_is_new_best", 64'(got.row_is_new_best), 64'(want.row_is_new_best));
        if (got.best_index !== want.best_index)
          report("best_index", 64'(got.best_index), 64'(want.best_index));
        if (got.best_valid !== want.best_valid)
          report("best_valid", 64'(got.best_valid), 64'(want.best_valid));
        if (got.empty_class !== want.empty_class)
          report("empty_class", 64'(got.empty_class), 64'(want.empty_class));
        if (got.done_res !== want.done_res)
          report("done_res", 64'(got.done_res), 64'(want.done_res));
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    while (row_results_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_t_statistic_feature_select: done, clean");
    end else begin
      $display("tb_t_statistic_feature_select: done, errors");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout, %0d results pending", row_results_q.size());
      $display("tb_t_statistic_feature_select: done, errors");
      $finish;
    end
  end

endmodule
